FILE: rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Function codes, field widths and bank tables.
// ----------------------------------------------------------------------------
`default_nettype none
package cbm_pkg;
  localparam int OuterRegCount = 8;
  localparam int InnerRegCount = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 12;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_CPU   = 2'd1,
    FUNC_PPU   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    TGT_ROM  = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_NONE = 2'd2
  } target_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SUBMAPPER  = 3'd0,
    CFG_OUTER_MASK = 3'd1,
    CFG_VAR523     = 3'd2,
    CFG_CHR_ROM    = 3'd3,
    CFG_CHR_RAM    = 3'd4,
    CFG_HDR_MIRROR = 3'd5
  } cfg_idx_t;

  localparam logic [15:0] OuterBase = 16'h5000;

  function automatic logic [7:0] prg_mode_mask(input logic [2:0] mode);
    case (mode)
      3'd0: prg_mode_mask = 8'h3F;
      3'd1: prg_mode_mask = 8'h1F;
      3'd2: prg_mode_mask = 8'h0F;
      3'd6: prg_mode_mask = 8'h7F;
      3'd7: prg_mode_mask = 8'hFF;
      default: prg_mode_mask = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] inner_init(input logic [3:0] i);
    case (i)
      4'd0: inner_init = 8'h00;
      4'd1: inner_init = 8'h02;
      4'd2: inner_init = 8'h04;
      4'd3: inner_init = 8'h05;
      4'd4: inner_init = 8'h06;
      4'd5: inner_init = 8'h07;
      4'd6: inner_init = 8'h00;
      4'd7: inner_init = 8'h01;
      4'd8: inner_init = 8'hFE;
      4'd9: inner_init = 8'hFF;
      4'd10: inner_init = 8'h01;
      4'd11: inner_init = 8'h03;
      default: inner_init = 8'h00;
    endcase
  endfunction

  function automatic logic [3:0] ext_idx(input logic [2:0] k);
    case (k)
      3'd0: ext_idx = 4'd0;
      3'd1: ext_idx = 4'd10;
      3'd2: ext_idx = 4'd1;
      3'd3: ext_idx = 4'd11;
      3'd4: ext_idx = 4'd2;
      3'd5: ext_idx = 4'd3;
      3'd6: ext_idx = 4'd4;
      default: ext_idx = 4'd5;
    endcase
  endfunction
endpackage
`default_nettype wire

FILE: rtl/cartridge_bank_mapper.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: multicart bank switching mapper
// Decodes CPU writes into mapper registers and translates CPU and PPU
// addresses into banks, target, write enable and mirroring.
// ----------------------------------------------------------------------------
// Use: the input channel carries one bus beat (func, address, data_in) with
// in_valid / in_stall; the result channel returns one beat per input beat
// with out_valid / out_stall. An input beat is registered, then decoded and
// translated by one stage of logic into the result register, and one beat is
// taken every cycle while in_stall is low. Register writes happen as the
// beat leaves the input register, so a lookup right behind a write sees it.
// A full result register under out_stall holds the input register, and
// in_stall rises only when both are full.
// The cfg port writes a board strap; a write to index 0..5 resets all mapper
// state under the new straps. rst_n (synchronous, active low) restores strap
// defaults and mapper state and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none
module cartridge_bank_mapper #(
  parameter int OUTER_REG_COUNT = cbm_pkg::OuterRegCount,
  parameter int INNER_REG_COUNT = cbm_pkg::InnerRegCount
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [cbm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [cbm_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_func,
  input  wire logic [15:0]                  in_address,
  input  wire logic [7:0]                   in_data_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [15:0]                       out_bank,
  output logic [1:0]                        out_target,
  output logic                              out_writable,
  output logic [1:0]                        out_mirroring
);
  import cbm_pkg::*;

  logic [2:0]  submapper_r;
  logic [11:0] osm_r;
  logic        v523_r, chr_rom_r, hdr_r;
  logic [1:0]  chr_ram_r;

  logic [7:0] outer_r [OUTER_REG_COUNT];
  logic [7:0] inner_r [INNER_REG_COUNT];
  logic [7:0] bsel_r, lastw_r, mirror_r, ramc_r, xouter_r;

  logic        iv_r;
  logic [1:0]  ifunc_r;
  logic [15:0] iaddr_r;
  logic [7:0]  idata_r;

  logic        ov_r;
  logic [15:0] obank_r;
  logic [1:0]  otgt_r, omir_r;
  logic        owr_r;

  logic adv, take;
  assign adv  = iv_r && !(ov_r && out_stall);
  assign in_stall = iv_r && !adv;
  assign take = in_valid && !in_stall;

  assign out_valid = ov_r;
  assign out_bank = obank_r;
  assign out_target = otgt_r;
  assign out_writable = owr_r;
  assign out_mirroring = omir_r;

  function automatic logic [7:0] rd_outer(input logic [7:0] o [OUTER_REG_COUNT],
                                          input logic [2:0] i);
    rd_outer = (32'(i) < OUTER_REG_COUNT) ? o[i] : 8'h00;
  endfunction
  function automatic logic [7:0] rd_inner(input logic [7:0] o [INNER_REG_COUNT],
                                          input logic [3:0] i);
    rd_inner = (32'(i) < INNER_REG_COUNT) ? o[i] : 8'h00;
  endfunction

  // state after the current write (write-through for the lookup)
  logic [7:0] on [OUTER_REG_COUNT];
  logic [7:0] inn [INNER_REG_COUNT];
  logic [7:0] bsel_n, lastw_n, mirror_n, ramc_n, xouter_n;
  logic       ext_c, cfg_c;
  logic [7:0]  o3_c;
  logic [15:0] m16, a;
  logic [3:0]  iidx;
  logic [2:0]  oidx;
  logic [2:0]  sm;

  always_comb begin
    on = outer_r;
    inn = inner_r;
    bsel_n = bsel_r;
    lastw_n = lastw_r;
    mirror_n = mirror_r;
    ramc_n = ramc_r;
    xouter_n = xouter_r;
    a = iaddr_r;
    sm = submapper_r;
    m16 = OuterBase | {4'd0, osm_r};
    oidx = (sm == 3'd3) ? a[2:0] : {1'b0, a[1:0]};
    o3_c = rd_outer(outer_r, 3'd3);
    ext_c = o3_c[1] && (sm == 3'd1 || sm == 3'd2 || v523_r);
    cfg_c = ramc_r[5] && sm == 3'd2;
    iidx = bsel_r[3:0] & (ext_c ? 4'hF : 4'h7);
    if (iv_r && ifunc_r == FUNC_WRITE) begin
      case (a[15:12])
        4'h4: if (a[11] && sm == 3'd5) xouter_n = idata_r;
        4'h5: begin
          if (!cfg_c || ramc_r[6]) begin
            if ((a & m16) == m16 && 32'(oidx) < OUTER_REG_COUNT) on[oidx] = idata_r;
          end
        end
        4'h8, 4'h9: begin
          lastw_n = idata_r;
          if (a[1:0] == 2'd0) begin
            bsel_n = (sm == 3'd2 && idata_r[6] && idata_r[2:0] >= 3'd6) ?
                     (idata_r ^ 8'h01) : idata_r;
          end else if (a[1:0] == 2'd1) begin
            if (32'(iidx) < INNER_REG_COUNT) inn[iidx] = idata_r;
          end
        end
        4'hA, 4'hB: begin
          lastw_n = idata_r;
          if (a[0]) ramc_n = idata_r;
          else mirror_n = idata_r;
        end
        4'hC, 4'hD, 4'hE, 4'hF: lastw_n = idata_r;
        default: ;
      endcase
    end
  end

  // lookup on updated state
  logic [31:0] prg, base, mask, sel, b16, cv, kk, bank;
  logic [1:0]  slot, tgt, mir;
  logic        wr, ext, rcfg;
  logic [2:0]  mode, k;
  logic [7:0]  o0, o2, o3;

  function automatic logic [31:0] chr_val(input logic [7:0] oo [OUTER_REG_COUNT],
      input logic [7:0] ii [INNER_REG_COUNT], input logic [2:0] s, input logic ex,
      input logic crom, input logic [1:0] cram, input logic [7:0] lw, input logic [2:0] kx);
    logic [31:0] b, m;
    logic [7:0] z0;
    z0 = rd_outer(oo, 3'd0);
    b = 32'(rd_outer(oo, 3'd2)) << 3;
    if (s == 3'd3) b = b | (32'(rd_outer(oo, 3'd6)) << 11);
    if ((z0 & 8'h60) != 8'h00 || (!crom && cram == 2'd1)) begin
      m = (!z0[5] && (s == 3'd1 || s == 3'd5)) ? (z0[4] ? 32'h08 : 32'h18) : 32'h0;
      b = ((s == 3'd5) ? b : (b & ~m)) | ((32'(lw) << 3) & m);
      chr_val = b | 32'(kx);
    end else begin
      m = z0[4] ? 32'h7F : 32'hFF;
      if (ex) chr_val = (b & ~m) | (32'(rd_inner(ii, ext_idx(kx))) & m);
      else if (!kx[2])
        chr_val = (b & ~m) | ((32'(rd_inner(ii, {3'd0, kx[1]})) & m) & ~32'h1) | 32'(kx[0]);
      else chr_val = (b & ~m) | (32'(rd_inner(ii, {1'b0, kx} - 4'd2)) & m);
    end
  endfunction

  always_comb begin
    o0 = rd_outer(on, 3'd0);
    o2 = rd_outer(on, 3'd2);
    o3 = rd_outer(on, 3'd3);
    ext = o3[1] && (sm == 3'd1 || sm == 3'd2 || v523_r);
    rcfg = ramc_n[5] && sm == 3'd2;
    mode = o0[2:0];
    mask = ext ? 32'hFF : 32'(prg_mode_mask(mode));
    base = 32'(rd_outer(on, 3'd1) & 8'h7F);
    slot = a[14:13];
    case (sm)
      3'd1: if (mode == 3'd7 || ext) mask = 32'hFF;
      3'd2: base = base | ((32'(o0) & 32'h08) << 4) | ((32'(o0) & 32'h80) << 1)
                 | ((32'(o2) & 32'hC0) << 3) | ((32'(o2) & 32'h20) << 6);
      3'd3: begin
        base = base | (32'(rd_outer(on, 3'd5)) << 7);
        if (mode == 3'd7) mask = 32'hFF;
      end
      3'd4: base = base | (32'(o2) & 32'h80);
      3'd5: base = (base & 32'h1F) | (32'(xouter_n) << 5);
      default: ;
    endcase
    b16 = 32'h0;
    sel = 32'h0;
    case (mode)
      3'd3: prg = base * 2 + 32'(slot[0]);
      3'd4: prg = (base >> 1) * 4 + 32'(slot);
      3'd5: begin
        b16 = (base & 32'hFFF8) | 32'(lastw_n[2:0]) | (slot[1] ? 32'h7 : 32'h0);
        prg = b16 * 2 + 32'(slot[0]);
      end
      default: begin
        if (bsel_n[6] && !slot[0]) slot = slot ^ 2'd2;
        case (slot)
          2'd0: sel = 32'(rd_inner(inn, 4'd6));
          2'd1: sel = 32'(rd_inner(inn, 4'd7));
          2'd2: sel = ext ? 32'(rd_inner(inn, 4'd8)) : 32'hFE;
          default: sel = ext ? 32'(rd_inner(inn, 4'd9)) : 32'hFF;
        endcase
        prg = ((base << 1) & ~mask) | (sel & mask);
      end
    endcase
    kk = 32'(((a & 16'h1C00) ^ (16'(bsel_n[7]) << 12)) >> 10);
    k = kk[2:0];
    cv = 32'h0;
    bank = 32'h0;
    tgt = TGT_NONE;
    wr = 1'b0;
    if (ifunc_r == FUNC_CPU) begin
      if (a[15]) begin
        bank = prg; tgt = TGT_ROM;
      end else if (a >= 16'h6000) begin
        if (rcfg) begin
          bank = 32'(ramc_n[1:0]); tgt = TGT_RAM; wr = 1'b1;
        end else if (ramc_n[7]) begin
          tgt = TGT_RAM; wr = !ramc_n[6];
        end
      end else if (a >= 16'h4000 && rcfg) begin
        bank = 32'(ramc_n[1:0]) + 32'd1; tgt = TGT_RAM; wr = 1'b1;
      end
    end else if (ifunc_r == FUNC_PPU && a < 16'h2000) begin
      if (v523_r) begin
        cv = chr_val(on, inn, sm, ext, chr_rom_r, chr_ram_r, lastw_n, {a[12:11], 1'b0});
        bank = cv * 2 + 32'(a[10]);
        tgt = chr_rom_r ? TGT_ROM : TGT_RAM;
      end else begin
        cv = chr_val(on, inn, sm, ext, chr_rom_r, chr_ram_r, lastw_n, k);
        bank = cv;
        if (((chr_ram_r != 2'd0 && o0[5] && !o0[6]) || rcfg) && ramc_n[2] && bank < 32'd8)
          tgt = TGT_RAM;
        else tgt = chr_rom_r ? TGT_ROM : TGT_RAM;
      end
      wr = (tgt == TGT_RAM);
    end
    mir = mirror_n[1:0] & (rcfg ? 2'd3 : 2'd1);
  end

  logic       rst_state;
  logic [2:0]  sm_nxt;
  logic [11:0] osm_nxt;
  logic        v523_nxt, crom_nxt, hdr_nxt;
  logic [1:0]  cram_nxt;
  always_comb begin
    sm_nxt = submapper_r; osm_nxt = osm_r; v523_nxt = v523_r;
    crom_nxt = chr_rom_r; cram_nxt = chr_ram_r; hdr_nxt = hdr_r;
    rst_state = 1'b0;
    if (!rst_n) begin
      sm_nxt = 3'd0; osm_nxt = 12'd16; v523_nxt = 1'b0;
      crom_nxt = 1'b1; cram_nxt = 2'd0; hdr_nxt = 1'b0; rst_state = 1'b1;
    end else if (cfg_we) begin
      rst_state = 1'b1;
      case (cfg_index)
        CFG_SUBMAPPER:  sm_nxt = cfg_data[2:0];
        CFG_OUTER_MASK: osm_nxt = cfg_data;
        CFG_VAR523:     v523_nxt = cfg_data[0];
        CFG_CHR_ROM:    crom_nxt = cfg_data[0];
        CFG_CHR_RAM:    cram_nxt = cfg_data[1:0];
        CFG_HDR_MIRROR: hdr_nxt = cfg_data[0];
        default: rst_state = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    submapper_r <= sm_nxt; osm_r <= osm_nxt; v523_r <= v523_nxt;
    chr_rom_r <= crom_nxt; chr_ram_r <= cram_nxt; hdr_r <= hdr_nxt;
    if (rst_state) begin
      for (int i = 0; i < OUTER_REG_COUNT; i++)
        outer_r[i] <= (i == 0 && (sm_nxt == 3'd1 || sm_nxt == 3'd3)) ? 8'h07 : 8'h00;
      for (int i = 0; i < INNER_REG_COUNT; i++) inner_r[i] <= inner_init(4'(i));
      bsel_r <= 8'h00; lastw_r <= 8'h00; ramc_r <= 8'h00; xouter_r <= 8'h00;
      mirror_r <= v523_nxt ? {7'd0, ~hdr_nxt} : 8'h00;
    end else if (adv) begin
      outer_r <= on; inner_r <= inn;
      bsel_r <= bsel_n; lastw_r <= lastw_n; ramc_r <= ramc_n;
      xouter_r <= xouter_n; mirror_r <= mirror_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (take) iv_r <= 1'b1;
      else if (adv) iv_r <= 1'b0;
      if (adv) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
    if (take) begin
      ifunc_r <= in_func; iaddr_r <= in_address; idata_r <= in_data_in;
    end
    if (adv) begin
      obank_r <= bank[15:0]; otgt_r <= tgt; owr_r <= wr; omir_r <= mir;
    end
  end
endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: cartridge bank mapper testbench
// Drives CPU writes and CPU/PPU lookups across several board strap settings,
// predicts every result beat in a scoreboard class and compares field by
// field, under random sender gaps, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import cbm_pkg::*;

  class mapper_scoreboard;
    bit [2:0]  submapper;
    bit [11:0] sel_mask;
    bit        v523, chr_rom, hdr_mir;
    bit [1:0]  chr_ram;
    bit [7:0]  outer_r [8];
    bit [7:0]  inner_r [16];
    bit [7:0]  bank_sel, last_wr, mirror_r, ram_ctl, extra_o;
    bit [20:0] exp_q [$];
    int        errors, checked;

    function void init_state();
      for (int i = 0; i < 8; i++) outer_r[i] = 0;
      for (int i = 0; i < 16; i++) inner_r[i] = 0;
      inner_r[0] = 0; inner_r[1] = 2; inner_r[2] = 4; inner_r[3] = 5;
      inner_r[4] = 6; inner_r[5] = 7; inner_r[6] = 0; inner_r[7] = 1;
      inner_r[8] = 8'hFE; inner_r[9] = 8'hFF; inner_r[10] = 1; inner_r[11] = 3;
      if (submapper == 1 || submapper == 3) outer_r[0] = 7;
      bank_sel = 0; last_wr = 0; ram_ctl = 0; extra_o = 0;
      mirror_r = v523 ? {7'd0, ~hdr_mir} : 8'd0;
    endfunction

    function void strap_defaults();
      submapper = 0; sel_mask = 16; v523 = 0; chr_rom = 1; chr_ram = 0; hdr_mir = 0;
      init_state();
    endfunction

    function void set_strap(cfg_idx_t idx, bit [11:0] v);
      case (idx)
        CFG_SUBMAPPER:  submapper = v[2:0];
        CFG_OUTER_MASK: sel_mask = v;
        CFG_VAR523:     v523 = v[0];
        CFG_CHR_ROM:    chr_rom = v[0];
        CFG_CHR_RAM:    chr_ram = v[1:0];
        CFG_HDR_MIRROR: hdr_mir = v[0];
        default: return;
      endcase
      init_state();
    endfunction

    function bit ram_cfg();
      return ram_ctl[5] && submapper == 2;
    endfunction

    function bit ext_mode();
      return outer_r[3][1] && (submapper == 1 || submapper == 2 || v523);
    endfunction

    function bit [7:0] mask_of(bit [2:0] m);
      case (m)
        0: return 8'h3F;
        1: return 8'h1F;
        2: return 8'h0F;
        6: return 8'h7F;
        7: return 8'hFF;
        default: return 8'h00;
      endcase
    endfunction

    function bit [31:0] prg_bank(bit [15:0] a);
      bit ext;
      bit [31:0] o0, o2, md, mask, base, slot, b16, sel;
      ext = ext_mode();
      o0 = outer_r[0]; o2 = outer_r[2];
      md = o0 & 7;
      mask = ext ? 32'hFF : mask_of(md[2:0]);
      base = outer_r[1] & 8'h7F;
      slot = (a >> 13) & 3;
      case (submapper)
        1: if (md == 7 || ext) mask = 32'hFF;
        2: base |= ((o0 & 8) << 4) | ((o0 & 32'h80) << 1) | ((o2 & 32'hC0) << 3)
                   | ((o2 & 32'h20) << 6);
        3: begin
          base |= 32'(outer_r[5]) << 7;
          if (md == 7) mask = 32'hFF;
        end
        4: base |= o2 & 32'h80;
        5: base = (base & 32'h1F) | (32'(extra_o) << 5);
        default: ;
      endcase
      case (md)
        3: return base * 2 + (slot & 1);
        4: return (base >> 1) * 4 + slot;
        5: begin
          b16 = (base & 32'hFFF8) | (last_wr & 7) | ((slot & 2) ? 7 : 0);
          return b16 * 2 + (slot & 1);
        end
        default: begin
          if (bank_sel[6] && !slot[0]) slot ^= 2;
          base <<= 1;
          case (slot)
            0: sel = inner_r[6];
            1: sel = inner_r[7];
            2: sel = ext ? inner_r[8] : 32'hFE;
            default: sel = ext ? inner_r[9] : 32'hFF;
          endcase
          return (base & ~mask) | (sel & mask);
        end
      endcase
    endfunction

    function bit [31:0] chr_value(bit [31:0] k);
      bit [31:0] o0, base, mask, ix;
      o0 = outer_r[0];
      base = 32'(outer_r[2]) << 3;
      if (submapper == 3) base |= 32'(outer_r[6]) << 11;
      if ((o0 & 32'h60) != 0 || (!chr_rom && chr_ram == 1)) begin
        mask = (!o0[5] && (submapper == 1 || submapper == 5)) ? (o0[4] ? 8 : 32'h18) : 0;
        base = (submapper == 5 ? base : (base & ~mask)) | ((32'(last_wr) << 3) & mask);
        return base | k;
      end
      mask = o0[4] ? 32'h7F : 32'hFF;
      if (ext_mode()) begin
        case (k & 7)
          0: ix = 0; 1: ix = 10; 2: ix = 1; 3: ix = 11;
          4: ix = 2; 5: ix = 3; 6: ix = 4; default: ix = 5;
        endcase
        return (base & ~mask) | (inner_r[ix] & mask);
      end
      if (k < 4) return (base & ~mask) | ((inner_r[k >> 1] & mask) & ~32'd1) | (k & 1);
      return (base & ~mask) | (inner_r[k - 2] & mask);
    endfunction

    function void cpu_write(bit [15:0] a, bit [7:0] v);
      bit [15:0] m;
      bit [3:0] idx;
      case (a[15:12])
        4'h4: begin
          if (a[11] && submapper == 5) extra_o = v;
          return;
        end
        4'h5: begin
          if (!ram_cfg() || ram_ctl[6]) begin
            m = 16'h5000 | {4'd0, sel_mask};
            if ((a & m) != m) return;
            idx = submapper == 3 ? {1'b0, a[2:0]} : {2'b0, a[1:0]};
            outer_r[idx[2:0]] = v;
          end
          return;
        end
        4'h8, 4'h9: begin
          if (a[1:0] == 0)
            bank_sel = (submapper == 2 && v[6] && v[2:0] >= 6) ? v ^ 8'd1 : v;
          else if (a[1:0] == 1) begin
            idx = bank_sel[3:0] & (ext_mode() ? 4'hF : 4'h7);
            inner_r[idx] = v;
          end
        end
        4'hA, 4'hB: if (a[0]) ram_ctl = v; else mirror_r = v;
        4'hC, 4'hD, 4'hE, 4'hF: ;
        default: return;
      endcase
      last_wr = v;
    endfunction

    function void note_beat(bit [1:0] f, bit [15:0] a, bit [7:0] d);
      bit [31:0] bank, v, k;
      bit [1:0] tgt, mir;
      bit wr, cfg, en;
      bank = 0; tgt = TGT_NONE; wr = 0;
      en = ram_ctl[7];
      if (f == FUNC_WRITE) cpu_write(a, d);
      cfg = ram_cfg();
      if (f == FUNC_CPU) begin
        if (a >= 16'h8000) begin
          bank = prg_bank(a); tgt = TGT_ROM;
        end else if (a >= 16'h6000) begin
          if (cfg) begin
            bank = ram_ctl & 3; tgt = TGT_RAM; wr = 1;
          end else if (en) begin
            bank = 0; tgt = TGT_RAM; wr = !ram_ctl[6];
          end
        end else if (a >= 16'h4000 && cfg) begin
          bank = (ram_ctl & 3) + 1; tgt = TGT_RAM; wr = 1;
        end
      end else if (f == FUNC_PPU && a < 16'h2000) begin
        if (v523) begin
          v = chr_value((a >> 10) & 6);
          bank = v * 2 + ((a >> 10) & 1);
          tgt = chr_rom ? TGT_ROM : TGT_RAM;
        end else begin
          k = ((a & 16'h1C00) ^ (32'(bank_sel & 8'h80) << 5)) >> 10;
          bank = chr_value(k & 7);
          if (((chr_ram != 0 && outer_r[0][5] && !outer_r[0][6]) || cfg) && ram_ctl[2]
              && bank < 8)
            tgt = TGT_RAM;
          else
            tgt = chr_rom ? TGT_ROM : TGT_RAM;
        end
        wr = tgt == TGT_RAM;
      end
      mir = mirror_r[1:0] & (cfg ? 2'd3 : 2'd1);
      exp_q.push_back({bank[15:0], tgt, wr, mir});
    endfunction

    function void check_beat(bit [15:0] b, bit [1:0] t, bit w, bit [1:0] m);
      bit [20:0] e;
      if (exp_q.size() == 0) begin
        $display("%0t unexpected beat bank=%h", $time, b);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      checked++;
      if (e[20:5] != b) begin
        $display("%0t bank exp %h got %h", $time, e[20:5], b); errors++;
      end
      if (e[4:3] != t) begin
        $display("%0t target exp %0d got %0d", $time, e[4:3], t); errors++;
      end
      if (e[2] != w) begin
        $display("%0t writable exp %0d got %0d", $time, e[2], w); errors++;
      end
      if (e[1:0] != m) begin
        $display("%0t mirroring exp %0d got %0d", $time, e[1:0], m); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we, in_valid, in_stall, out_valid, out_stall, out_writable;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic [1:0] in_func, out_target, out_mirroring;
  logic [15:0] in_address, out_bank;
  logic [7:0] in_data_in;
  int send_idle, recv_idle, hold_cycles, sent;
  mapper_scoreboard sb;

  cartridge_bank_mapper u_top (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_beat(out_bank, out_target, out_writable,
                                                         out_mirroring);
    if (rst_n && in_valid && !in_stall) sb.note_beat(in_func, in_address, in_data_in);
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles--;
    end else
      out_stall <= ($urandom_range(99) < recv_idle);
  end

  // leaves in_valid high; an idle gap in the next call or drain() takes it down
  task automatic send_beat(bit [1:0] f, bit [15:0] a, bit [7:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_func <= f; in_address <= a; in_data_in <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 0;
    while (sb.exp_q.size() != 0 && n < 100000) begin
      @(negedge clk);
      n++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_strap(cfg_idx_t idx, bit [11:0] v);
    drain();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.set_strap(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // random beat: writes, mostly to decoded register space, CPU/PPU lookups or FUNC_NONE
  task automatic random_beat();
    bit [15:0] a;
    bit [1:0] f;
    int r;
    r = $urandom_range(99);
    a = 16'($urandom);
    if (r < 40) begin
      f = FUNC_WRITE;
      case ($urandom_range(4))
        0: a = {4'h5, a[11:0]} | {4'h0, sb.sel_mask};
        1: a = {3'b100, a[12:2], 1'b0, a[0]};
        2: a = {3'b101, a[12:0]};
        3: a = {4'h4, 1'b1, a[10:0]};
        default: ;
      endcase
    end else if (r < 70) f = FUNC_CPU;
    else if (r < 97) begin
      f = FUNC_PPU;
      if ($urandom_range(3) != 0) a[15:13] = 0;
    end else f = FUNC_NONE;
    send_beat(f, a, 8'($urandom));
  endtask

  initial begin
    sb = new();
    sb.strap_defaults();
    rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0; in_func = 0;
    in_address = 0; in_data_in = 0; out_stall = 0; send_idle = 0; recv_idle = 0;
    hold_cycles = 0; sent = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    // directed: extremes, every func, write then lookup
    send_beat(FUNC_CPU, 16'hFFFF, 0);
    send_beat(FUNC_CPU, 16'h8000, 0);
    send_beat(FUNC_CPU, 16'h0000, 8'hFF);
    send_beat(FUNC_CPU, 16'h6000, 0);
    send_beat(FUNC_PPU, 16'h0000, 0);
    send_beat(FUNC_PPU, 16'h1FFF, 0);
    send_beat(FUNC_PPU, 16'h2000, 0);
    send_beat(FUNC_NONE, 16'hFFFF, 8'hFF);
    send_beat(FUNC_WRITE, 16'h8000, 8'hC7);
    send_beat(FUNC_WRITE, 16'h8001, 8'hFF);
    send_beat(FUNC_WRITE, 16'hA001, 8'hFF);
    send_beat(FUNC_WRITE, 16'hA000, 8'h03);
    send_beat(FUNC_WRITE, 16'h5FFF, 8'hFF);
    send_beat(FUNC_WRITE, 16'h5013, 8'h02);
    send_beat(FUNC_CPU, 16'hE000, 0);
    send_beat(FUNC_CPU, 16'h4000, 0);
    send_beat(FUNC_PPU, 16'h0C00, 0);
    send_beat(FUNC_WRITE, 16'h4800, 8'hFF);
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_strap(CFG_SUBMAPPER, 1);
        1: begin
          write_strap(CFG_SUBMAPPER, 2); write_strap(CFG_OUTER_MASK, 0);
        end
        2: begin
          write_strap(CFG_SUBMAPPER, 3); write_strap(CFG_OUTER_MASK, 12'hFFF);
        end
        3: begin
          write_strap(CFG_OUTER_MASK, 16); write_strap(CFG_SUBMAPPER, 4);
        end
        4: write_strap(CFG_SUBMAPPER, 5);
        5: begin
          write_strap(CFG_SUBMAPPER, 7); write_strap(CFG_VAR523, 1);
          write_strap(CFG_HDR_MIRROR, 1);
        end
        6: begin
          write_strap(CFG_SUBMAPPER, 2); write_strap(CFG_CHR_ROM, 0);
          write_strap(CFG_CHR_RAM, 1);
        end
        7: begin
          write_strap(CFG_VAR523, 0); write_strap(CFG_CHR_RAM, 2);
          write_strap(CFG_SUBMAPPER, 1);
        end
        8: begin
          write_strap(CFG_SUBMAPPER, 6); write_strap(CFG_HDR_MIRROR, 0);
          write_strap(CFG_CHR_ROM, 1); write_strap(CFG_CHR_RAM, 3);
        end
        default: write_strap(CFG_SUBMAPPER, 0);
      endcase
      case (ph % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 65; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 65; end
        default: begin send_idle = 6; recv_idle = 6; end
      endcase
      if (ph == 4) hold_cycles = 60;
      repeat (75) random_beat();
    end
    drain();
    $display("covered %0d beats over ten strap settings, %0d results checked",
             sent, sb.checked);
    if (sb.errors == 0 && sb.exp_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
